// File: hdl/rsts_pkg.sv
package rsts_pkg;

    // slot count served by the selector; summaries at or beyond it are ignored
    localparam int unsigned SLOT_COUNT = 16;

    localparam int unsigned SLOT_IDX_W = 4;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned OUTCOME_W  = 2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_OK      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_CORRUPT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL    = 2'd3;

    // one slot summary beat
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_no;
        logic                  slot_erased;
        logic                  header_known;
        logic                  id_length_ok;
        logic                  checksum_good;
        logic                  uid_match;
        logic [COUNT_W-1:0]    sessions_count;
        logic [COUNT_W-1:0]    rounds_count;
        logic                  last_slot;
    } in_beat_t;

    // one write target beat
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] dest_slot;
        logic [OUTCOME_W-1:0]  outcome;
    } out_beat_t;

    // remembered slot: present flag plus index
    typedef struct packed {
        logic                  has;
        logic [SLOT_IDX_W-1:0] idx;
    } slot_ref_t;

endpackage

// File: hdl/record_slot_target_selector.sv
// Record slot target selector. Slot summaries arrive one beat per cycle, in slot order,
// and each is classified as empty, valid, corrupt or unknown; the block tracks the own
// valid slot, the own corrupt slot, the first empty slot, the first other bad slot and
// the least used valid slot (fewest sessions, then fewest rounds, earliest on a tie).
// The beat flagged last_slot puts one write target beat on m_valid once it has passed
// the update stage, chosen in that priority order, and the scan state clears for the next
// pass. Throughput is one summary per cycle: a summary goes through an input register,
// one compare-and-update stage, and a result register. A held result only stalls the
// input when a second last_slot beat reaches the update stage before the first is taken.
module record_slot_target_selector (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsts_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsts_pkg::out_beat_t  m_data
);

    localparam rsts_pkg::slot_ref_t NO_SLOT = '{has: 1'b0, idx: '0};

    logic                in_valid_reg;
    rsts_pkg::in_beat_t  in_reg;
    logic                stall;
    logic                adv;

    rsts_pkg::slot_ref_t own_reg, own_next;
    rsts_pkg::slot_ref_t own_bad_reg, own_bad_next;
    rsts_pkg::slot_ref_t empty_reg, empty_next;
    rsts_pkg::slot_ref_t bad_reg, bad_next;
    rsts_pkg::slot_ref_t evict_reg, evict_next;
    logic [rsts_pkg::COUNT_W-1:0] evict_sessions_reg, evict_sessions_next;
    logic [rsts_pkg::COUNT_W-1:0] evict_rounds_reg, evict_rounds_next;

    logic                out_valid_reg;
    rsts_pkg::out_beat_t out_reg;
    rsts_pkg::out_beat_t result;

    // update stage waits only when a last beat meets a finished target that is still unread
    assign stall   = in_valid_reg && in_reg.last_slot && out_valid_reg && !m_ready;
    assign adv     = in_valid_reg && !stall;
    assign s_ready = !in_valid_reg || !stall;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // classify the slot and update the scan state
    always_comb begin
        logic match;
        logic in_range;
        logic better;
        match    = in_reg.uid_match && in_reg.id_length_ok;
        in_range = 32'(in_reg.slot_no) < rsts_pkg::SLOT_COUNT;
        better   = 1'b0;

        own_next            = own_reg;
        own_bad_next        = own_bad_reg;
        empty_next          = empty_reg;
        bad_next            = bad_reg;
        evict_next          = evict_reg;
        evict_sessions_next = evict_sessions_reg;
        evict_rounds_next   = evict_rounds_reg;

        if (in_range) begin
            if (in_reg.slot_erased) begin
                if (!empty_reg.has) begin
                    empty_next = '{has: 1'b1, idx: in_reg.slot_no};
                end
            end else if (!in_reg.header_known
                         || !(in_reg.id_length_ok && in_reg.checksum_good)) begin
                if (in_reg.header_known && match) begin
                    own_bad_next = '{has: 1'b1, idx: in_reg.slot_no};
                end else if (!bad_reg.has) begin
                    bad_next = '{has: 1'b1, idx: in_reg.slot_no};
                end
            end else begin
                if (match) begin
                    own_next = '{has: 1'b1, idx: in_reg.slot_no};
                end
                if (!evict_reg.has) begin
                    better = 1'b1;
                end else if (in_reg.sessions_count != evict_sessions_reg) begin
                    better = in_reg.sessions_count < evict_sessions_reg;
                end else begin
                    better = in_reg.rounds_count < evict_rounds_reg;
                end
                if (better) begin
                    evict_next          = '{has: 1'b1, idx: in_reg.slot_no};
                    evict_sessions_next = in_reg.sessions_count;
                    evict_rounds_next   = in_reg.rounds_count;
                end
            end
        end
    end

    // pick the write target in priority order
    always_comb begin
        result.dest_slot = '0;
        result.outcome   = rsts_pkg::OUT_FULL;
        if (own_next.has) begin
            result.dest_slot = own_next.idx;
            result.outcome   = rsts_pkg::OUT_OK;
        end else if (own_bad_next.has) begin
            result.dest_slot = own_bad_next.idx;
            result.outcome   = rsts_pkg::OUT_CORRUPT;
        end else if (empty_next.has) begin
            result.dest_slot = empty_next.idx;
            result.outcome   = rsts_pkg::OUT_OK;
        end else if (bad_next.has) begin
            result.dest_slot = bad_next.idx;
            result.outcome   = rsts_pkg::OUT_CORRUPT;
        end else if (evict_next.has) begin
            result.dest_slot = evict_next.idx;
            result.outcome   = rsts_pkg::OUT_EVICT;
        end
    end

    // scan state, cleared after the last beat of a scan
    always_ff @(posedge aclk) begin
        if (!aresetn || (adv && in_reg.last_slot)) begin
            own_reg            <= NO_SLOT;
            own_bad_reg        <= NO_SLOT;
            empty_reg          <= NO_SLOT;
            bad_reg            <= NO_SLOT;
            evict_reg          <= NO_SLOT;
            evict_sessions_reg <= '1;
            evict_rounds_reg   <= '1;
        end else if (adv) begin
            own_reg            <= own_next;
            own_bad_reg        <= own_bad_next;
            empty_reg          <= empty_next;
            bad_reg            <= bad_next;
            evict_reg          <= evict_next;
            evict_sessions_reg <= evict_sessions_next;
            evict_rounds_reg   <= evict_rounds_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && in_reg.last_slot) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv && in_reg.last_slot) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // a last beat that leaves the update stage always shows a target next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_reg.last_slot |=> m_valid)
        else $error("last beat produced no target");

    // the scan state is empty right after a last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_reg.last_slot |=> !own_reg.has && !own_bad_reg.has && !empty_reg.has
                                    && !bad_reg.has && !evict_reg.has)
        else $error("scan state not cleared after last beat");

    // no slot available always reports slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outcome == rsts_pkg::OUT_FULL |-> m_data.dest_slot == '0)
        else $error("full outcome with nonzero target");

    // without a candidate the eviction counts sit at all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        !evict_reg.has |-> (&evict_sessions_reg) && (&evict_rounds_reg))
        else $error("eviction counts moved without a candidate");

endmodule
